// File: rtl/core/bbc_pkg.sv
// Bracket balance checker package: command word, bracket kinds, status codes,
// character constants and queue sizes, shared by the front, queue and back modules.
// No dependencies.
package bbc_pkg;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MISMATCH = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_UNCLOSED = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef struct packed {
    op_t   op;
    kind_t kind;
    logic  last;
  } cmd_t;

  localparam logic [7:0] CH_LROUND  = 8'h28;
  localparam logic [7:0] CH_RROUND  = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LCURLY  = 8'h7B;
  localparam logic [7:0] CH_RCURLY  = 8'h7D;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

endpackage

// File: rtl/core/bbc_in_if.sv
// Input channel of the bracket balance checker: one character word per handshake.
// No dependencies.
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

// File: rtl/core/bbc_out_if.sv
// Result channel of the bracket balance checker: one verdict word per expression.
// No dependencies.
interface bbc_out_if;
  logic       valid;
  logic       ready;
  logic       balanced;
  logic [2:0] status;

  modport source (output valid, output balanced, output status, input ready);
  modport sink   (input valid, input balanced, input status, output ready);
endinterface

// File: rtl/core/bbc_front.sv
// Front end: accepts character words and classifies them into stack commands.
// Depends on bbc_pkg and bbc_in_if.
module bbc_front (
  bbc_in_if.sink         chars,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output bbc_pkg::cmd_t  cmd
);

  assign cmd_valid   = chars.valid;
  assign chars.ready = cmd_ready;

  always_comb begin
    cmd.last = chars.last;
    unique case (chars.symbol)
      bbc_pkg::CH_LROUND: begin
        cmd.op   = bbc_pkg::OP_OPEN;
        cmd.kind = bbc_pkg::KIND_ROUND;
      end
      bbc_pkg::CH_LSQUARE: begin
        cmd.op   = bbc_pkg::OP_OPEN;
        cmd.kind = bbc_pkg::KIND_SQUARE;
      end
      bbc_pkg::CH_LCURLY: begin
        cmd.op   = bbc_pkg::OP_OPEN;
        cmd.kind = bbc_pkg::KIND_CURLY;
      end
      bbc_pkg::CH_RROUND: begin
        cmd.op   = bbc_pkg::OP_CLOSE;
        cmd.kind = bbc_pkg::KIND_ROUND;
      end
      bbc_pkg::CH_RSQUARE: begin
        cmd.op   = bbc_pkg::OP_CLOSE;
        cmd.kind = bbc_pkg::KIND_SQUARE;
      end
      bbc_pkg::CH_RCURLY: begin
        cmd.op   = bbc_pkg::OP_CLOSE;
        cmd.kind = bbc_pkg::KIND_CURLY;
      end
      default: begin
        cmd.op   = bbc_pkg::OP_NONE;
        cmd.kind = bbc_pkg::KIND_ROUND;
      end
    endcase
  end

endmodule

// File: rtl/core/bbc_queue.sv
// Short command queue between the front end and the stack engine.
// Depends on bbc_pkg.
module bbc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  bbc_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  logic          rd_take,
  output bbc_pkg::cmd_t rd_cmd
);

  bbc_pkg::cmd_t                  slots [bbc_pkg::QUEUE_DEPTH];
  logic [bbc_pkg::QUEUE_AW-1:0]   wr_ptr;
  logic [bbc_pkg::QUEUE_AW-1:0]   rd_ptr;
  logic [bbc_pkg::QUEUE_CW-1:0]   fill;
  logic                           push;
  logic                           pop;

  assign wr_ready = (fill != bbc_pkg::QUEUE_CW'(bbc_pkg::QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_cmd   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == bbc_pkg::QUEUE_AW'(bbc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == bbc_pkg::QUEUE_AW'(bbc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/bbc_back.sv
// Stack engine: carries out push and pop commands on the bracket stack memory,
// keeps the sticky error and registers the verdict word. Depends on bbc_pkg, bbc_out_if.
module bbc_back #(
  parameter int STACK_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_take,
  input  bbc_pkg::cmd_t cmd,
  bbc_out_if.source     results
);

  localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [1:0]       stack_mem [STACK_DEPTH];
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  bbc_pkg::status_t err;
  bbc_pkg::status_t err_next;
  bbc_pkg::status_t err_upd;
  bbc_pkg::status_t verdict;
  logic [1:0]       top;
  logic             push;
  logic [IW-1:0]    rd_addr;
  logic [CW-1:0]    count_upd;

  assign cmd_take = cmd_valid && (!cmd.last || !results.valid || results.ready);

  always_comb begin
    push      = 1'b0;
    count_upd = count;
    err_upd   = err;
    if (cmd_take && err == bbc_pkg::ST_OK) begin
      case (cmd.op)
        bbc_pkg::OP_OPEN: begin
          if (count == CW'(STACK_DEPTH)) begin
            err_upd = bbc_pkg::ST_OVERFLOW;
          end else begin
            push      = 1'b1;
            count_upd = count + 1'b1;
          end
        end
        bbc_pkg::OP_CLOSE: begin
          if (count == '0) begin
            err_upd = bbc_pkg::ST_EMPTY;
          end else begin
            count_upd = count - 1'b1;
            if (top != cmd.kind) begin
              err_upd = bbc_pkg::ST_MISMATCH;
            end
          end
        end
        default: ;
      endcase
    end

    if (err_upd != bbc_pkg::ST_OK) begin
      verdict = err_upd;
    end else if (count_upd != '0) begin
      verdict = bbc_pkg::ST_UNCLOSED;
    end else begin
      verdict = bbc_pkg::ST_OK;
    end

    if (cmd_take && cmd.last) begin
      count_next = '0;
      err_next   = bbc_pkg::ST_OK;
    end else begin
      count_next = count_upd;
      err_next   = err_upd;
    end
  end

  assign rd_addr = IW'(count_next - 1'b1);

  // hold the top entry in a register; bypass a fresh push around the memory
  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[count[IW-1:0]] <= cmd.kind;
      top                      <= cmd.kind;
    end else begin
      top <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      err           <= bbc_pkg::ST_OK;
      results.valid <= 1'b0;
    end else begin
      count <= count_next;
      err   <= err_next;
      if (cmd_take && cmd.last) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take && cmd.last) begin
      results.status   <= verdict;
      results.balanced <= (verdict == bbc_pkg::ST_OK);
    end
  end

endmodule

// File: rtl/core/bracket_balance_checker_top.sv
// Bracket balance checker: one character word in per cycle, one verdict word out
// per expression. A character word is taken every cycle while the command queue
// has room; the back end retires one command per cycle unless a last command
// waits on an untaken verdict, each at most one push or pop on the stack memory
// with the top entry held in a register, so the sustained rate is one character
// per cycle. The last character's command passes through the queue before the
// stack engine takes it and registers the verdict on the result channel, where
// it waits until taken while later characters keep flowing. The stack holds STACK_DEPTH
// entries; status is 0 ok, 1 kind mismatch, 2 closer on empty, 3 unclosed,
// 4 overflow, and the first error of an expression is the one reported.
// Depends on bbc_pkg, bbc_in_if, bbc_out_if, bbc_front, bbc_queue, bbc_back.
module bracket_balance_checker_top #(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  bbc_in_if.sink    chars,
  bbc_out_if.source results
);

  bbc_pkg::cmd_t front_cmd;
  bbc_pkg::cmd_t queue_cmd;
  logic          front_valid;
  logic          front_ready;
  logic          queue_valid;
  logic          queue_take;

  bbc_front u_front (
    .chars     (chars),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  bbc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_cmd   (front_cmd),
    .rd_valid (queue_valid),
    .rd_take  (queue_take),
    .rd_cmd   (queue_cmd)
  );

  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (queue_valid),
    .cmd_take  (queue_take),
    .cmd       (queue_cmd),
    .results   (results)
  );

`ifndef SYNTHESIS
  a_verdict_consistent: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.balanced == (results.status == bbc_pkg::ST_OK)))
    else $error("balanced flag disagrees with status");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.status <= bbc_pkg::ST_OVERFLOW))
    else $error("status code out of range");

  a_take_needs_valid: assert property (@(posedge clk) disable iff (rst)
    queue_take |-> queue_valid)
    else $error("stack engine took a command from an empty queue");

  a_quiet_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !results.valid)
    else $error("result word shown straight after reset");

  a_last_yields_result: assert property (@(posedge clk) disable iff (rst)
    (queue_take && queue_cmd.last) |=> results.valid)
    else $error("last character retired without a verdict");
`endif

endmodule

// File: tb/sv/testbench.sv
// Testbench for bracket_balance_checker_top: drives character words through a directed
// table and random expressions, takes each expected verdict word from the table or predicts
// it, and checks it field by field. Depends on bbc_pkg, bbc_in_if, bbc_out_if and the checker RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int STACK_DEPTH = 64;
  localparam int WORD_TARGET = 1700;
  localparam int IDLE_LIMIT  = 4000;
  localparam int NUM_ROWS    = 27;

  typedef struct packed {
    logic             balanced;
    bbc_pkg::status_t status;
  } verdict_t;

  typedef struct packed {
    logic [7:0]       symbol;
    logic             last;
    logic [6:0]       reps;
    bit               typed;
    logic             balanced;
    bbc_pkg::status_t status;
  } row_t;

  logic clk = 1'b0;
  logic rst;

  bbc_in_if  chars ();
  bbc_out_if results ();

  bracket_balance_checker_top #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .results (results)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bbc_pkg::kind_t   nest_stack [STACK_DEPTH];
  int unsigned      nest_depth  = 0;
  bbc_pkg::status_t first_fault = bbc_pkg::ST_OK;

  verdict_t    verdicts_due [$];
  int unsigned words_sent    = 0;
  int unsigned fault_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned idle_cycles   = 0;

  row_t directed_rows [NUM_ROWS] = '{
    '{8'h00,               1'b1, 7'd1,  1'b1, 1'b1, bbc_pkg::ST_OK},
    '{8'hFF,               1'b1, 7'd1,  1'b1, 1'b1, bbc_pkg::ST_OK},
    '{bbc_pkg::CH_LROUND,  1'b0, 7'd1,  1'b0, 1'b0, bbc_pkg::ST_OK},
    '{bbc_pkg::CH_RROUND,  1'b1, 7'd1,  1'b1, 1'b1, bbc_pkg::ST_OK},
    '{bbc_pkg::CH_LSQUARE, 1'b0, 7'd1,  1'b0, 1'b0, bbc_pkg::ST_OK},
    '{8'h41,               1'b0, 7'd1,  1'b0, 1'b0, bbc_pkg::ST_OK},
    '{bbc_pkg::CH_RSQUARE, 1'b1, 7'd1,  1'b0, 1'b0, bbc_pkg::ST_OK},
    '{bbc_pkg::CH_LCURLY,  1'b0, 7'd1,  1'b0, 1'b0, bbc_pkg::ST_OK},
    '{bbc_pkg::CH_RCURLY,  1'b1, 7'd1,  1'b0, 1'b0, bbc_pkg::ST_OK},
    '{bbc_pkg::CH_LROUND,  1'b0, 7'd1,  1'b0, 1'b0, bbc_pkg::ST_OK},
    '{bbc_pkg::CH_RSQUARE, 1'b1, 7'd1,  1'b1, 1'b0, bbc_pkg::ST_MISMATCH},
    '{bbc_pkg::CH_RCURLY,  1'b1, 7'd1,  1'b1, 1'b0, bbc_pkg::ST_EMPTY},
    '{bbc_pkg::CH_LCURLY,  1'b1, 7'd1,  1'b1, 1'b0, bbc_pkg::ST_UNCLOSED},
    '{bbc_pkg::CH_LSQUARE, 1'b0, 7'd64, 1'b0, 1'b0, bbc_pkg::ST_OK},
    '{bbc_pkg::CH_LROUND,  1'b1, 7'd1,  1'b1, 1'b0, bbc_pkg::ST_OVERFLOW},
    '{bbc_pkg::CH_LCURLY,  1'b0, 7'd64, 1'b0, 1'b0, bbc_pkg::ST_OK},
    '{bbc_pkg::CH_RCURLY,  1'b0, 7'd63, 1'b0, 1'b0, bbc_pkg::ST_OK},
    '{bbc_pkg::CH_RCURLY,  1'b1, 7'd1,  1'b0, 1'b0, bbc_pkg::ST_OK},
    '{bbc_pkg::CH_RROUND,  1'b0, 7'd1,  1'b0, 1'b0, bbc_pkg::ST_OK},
    '{bbc_pkg::CH_LROUND,  1'b0, 7'd1,  1'b0, 1'b0, bbc_pkg::ST_OK},
    '{bbc_pkg::CH_RROUND,  1'b1, 7'd1,  1'b1, 1'b0, bbc_pkg::ST_EMPTY},
    '{bbc_pkg::CH_LSQUARE, 1'b0, 7'd1,  1'b0, 1'b0, bbc_pkg::ST_OK},
    '{bbc_pkg::CH_RCURLY,  1'b0, 7'd1,  1'b0, 1'b0, bbc_pkg::ST_OK},
    '{bbc_pkg::CH_RSQUARE, 1'b1, 7'd1,  1'b1, 1'b0, bbc_pkg::ST_MISMATCH},
    '{bbc_pkg::CH_LROUND,  1'b0, 7'd64, 1'b0, 1'b0, bbc_pkg::ST_OK},
    '{bbc_pkg::CH_LROUND,  1'b0, 7'd1,  1'b0, 1'b0, bbc_pkg::ST_OK},
    '{bbc_pkg::CH_RROUND,  1'b1, 7'd1,  1'b1, 1'b0, bbc_pkg::ST_OVERFLOW}
  };

  function automatic void decode_symbol(input logic [7:0] sym, output bbc_pkg::op_t op,
                                        output bbc_pkg::kind_t kd);
    op = bbc_pkg::OP_NONE;
    kd = bbc_pkg::KIND_ROUND;
    case (sym)
      bbc_pkg::CH_LROUND:  begin op = bbc_pkg::OP_OPEN;  kd = bbc_pkg::KIND_ROUND;  end
      bbc_pkg::CH_LSQUARE: begin op = bbc_pkg::OP_OPEN;  kd = bbc_pkg::KIND_SQUARE; end
      bbc_pkg::CH_LCURLY:  begin op = bbc_pkg::OP_OPEN;  kd = bbc_pkg::KIND_CURLY;  end
      bbc_pkg::CH_RROUND:  begin op = bbc_pkg::OP_CLOSE; kd = bbc_pkg::KIND_ROUND;  end
      bbc_pkg::CH_RSQUARE: begin op = bbc_pkg::OP_CLOSE; kd = bbc_pkg::KIND_SQUARE; end
      bbc_pkg::CH_RCURLY:  begin op = bbc_pkg::OP_CLOSE; kd = bbc_pkg::KIND_CURLY;  end
      default:             op = bbc_pkg::OP_NONE;
    endcase
  endfunction

  function automatic logic [7:0] opener_of(input bbc_pkg::kind_t kd);
    case (kd)
      bbc_pkg::KIND_SQUARE: return bbc_pkg::CH_LSQUARE;
      bbc_pkg::KIND_CURLY:  return bbc_pkg::CH_LCURLY;
      default:              return bbc_pkg::CH_LROUND;
    endcase
  endfunction

  function automatic logic [7:0] closer_of(input bbc_pkg::kind_t kd);
    case (kd)
      bbc_pkg::KIND_SQUARE: return bbc_pkg::CH_RSQUARE;
      bbc_pkg::KIND_CURLY:  return bbc_pkg::CH_RCURLY;
      default:              return bbc_pkg::CH_RROUND;
    endcase
  endfunction

  function automatic bbc_pkg::kind_t any_kind();
    return bbc_pkg::kind_t'($urandom_range(0, 2));
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0]     b;
    bbc_pkg::op_t   op;
    bbc_pkg::kind_t kd;
    do begin
      b = any_byte();
      decode_symbol(b, op, kd);
    end while (op != bbc_pkg::OP_NONE);
    return b;
  endfunction

  // advance the nesting state by one character; yield a verdict on the last one
  function automatic bit tally_word(input logic [7:0] sym, input logic lst,
                                    output verdict_t v);
    bbc_pkg::op_t     op;
    bbc_pkg::kind_t   kd;
    bbc_pkg::status_t st;
    v = '0;
    decode_symbol(sym, op, kd);
    if (first_fault == bbc_pkg::ST_OK) begin
      if (op == bbc_pkg::OP_OPEN) begin
        if (nest_depth >= STACK_DEPTH) begin
          first_fault = bbc_pkg::ST_OVERFLOW;
        end else begin
          nest_stack[nest_depth] = kd;
          nest_depth++;
        end
      end else if (op == bbc_pkg::OP_CLOSE) begin
        if (nest_depth == 0) begin
          first_fault = bbc_pkg::ST_EMPTY;
        end else begin
          nest_depth--;
          if (nest_stack[nest_depth] != kd) first_fault = bbc_pkg::ST_MISMATCH;
        end
      end
    end
    if (!lst) return 1'b0;
    if (first_fault != bbc_pkg::ST_OK) st = first_fault;
    else if (nest_depth != 0) st = bbc_pkg::ST_UNCLOSED;
    else st = bbc_pkg::ST_OK;
    v.balanced  = (st == bbc_pkg::ST_OK);
    v.status    = st;
    nest_depth  = 0;
    first_fault = bbc_pkg::ST_OK;
    return 1'b1;
  endfunction

  task automatic send_word(input logic [7:0] sym, input logic lst, input bit typed,
                           input verdict_t typed_v);
    verdict_t v;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      chars.valid <= 1'b0;
      @(posedge clk);
    end
    chars.valid  <= 1'b1;
    chars.symbol <= sym;
    chars.last   <= lst;
    @(posedge clk);
    while (!chars.ready) @(posedge clk);
    words_sent++;
    if (tally_word(sym, lst, v)) verdicts_due.push_back(typed ? typed_v : v);
  endtask

  // mostly well-formed nesting with noise characters, a share of it then broken
  task automatic play_expression();
    logic [7:0]     seq [$];
    bbc_pkg::kind_t open_kinds [$];
    int             pick, steps, depth_cap, r, pos;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      depth_cap = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2);
      repeat (depth_cap) begin
        open_kinds.push_back(any_kind());
        seq.push_back(opener_of(open_kinds[$]));
      end
    end else if (pick < 11) begin
      repeat ($urandom_range(1, 6)) seq.push_back(any_byte());
    end else begin
      steps     = $urandom_range(1, 20);
      depth_cap = $urandom_range(1, 8);
      repeat (steps) begin
        r = $urandom_range(0, 9);
        if (r < 2) begin
          seq.push_back(plain_char());
        end else if (open_kinds.size() < depth_cap && (open_kinds.size() == 0 || r < 6)) begin
          open_kinds.push_back(any_kind());
          seq.push_back(opener_of(open_kinds[$]));
        end else begin
          seq.push_back(closer_of(open_kinds.pop_back()));
        end
      end
    end
    while (open_kinds.size() != 0) seq.push_back(closer_of(open_kinds.pop_back()));
    if (seq.size() == 0) seq.push_back(plain_char());
    if (pick >= 11 && $urandom_range(0, 99) < 30) begin
      pos = $urandom_range(0, seq.size() - 1);
      case ($urandom_range(0, 3))
        0: seq[pos] = closer_of(any_kind());
        1: seq.insert(pos, closer_of(any_kind()));
        2: repeat ($urandom_range(1, seq.size() - 1)) void'(seq.pop_back());
        default: seq[pos] = any_byte();
      endcase
    end
    foreach (seq[i]) send_word(seq[i], i == seq.size() - 1, 1'b0, '0);
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      results.ready <= ($urandom_range(0, 99) >= stall_pct);
      if (results.valid && results.ready) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict word with none due: balanced %0d status %0d",
                 results.balanced, results.status);
          fault_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (results.balanced !== want.balanced) begin
            $error("balanced: expected %0d, got %0d", want.balanced, results.balanced);
            fault_count++;
          end
          if (results.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, results.status);
            fault_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((chars.valid && chars.ready) || (results.valid && results.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    rst           <= 1'b1;
    chars.valid   <= 1'b0;
    chars.symbol  <= 8'h00;
    chars.last    <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      repeat (directed_rows[i].reps)
        send_word(directed_rows[i].symbol, directed_rows[i].last, directed_rows[i].typed,
                  '{directed_rows[i].balanced, directed_rows[i].status});
    end

    while (words_sent < WORD_TARGET) begin
      phase = words_sent * 4 / WORD_TARGET;
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 80; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 80; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      play_expression();
    end
    chars.valid <= 1'b0;

    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fault_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
